/* src/rpqp_pkg.sv */
package rpqp_pkg;

   // line geometry
   localparam int MAX_LINE_PIXELS = 1024;
   localparam int COL_W           = $clog2(MAX_LINE_PIXELS + 1);

   // register file
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PALETTE0 = 3'd0,
      CSR_PALETTE1 = 3'd1,
      CSR_PALETTE2 = 3'd2,
      CSR_PALETTE3 = 3'd3,
      CSR_CODES    = 3'd4,
      CSR_FILL     = 3'd5,
      CSR_WIDTH    = 3'd6
   } csr_index_type;

   // reset values of the registers
   localparam logic [23:0] PALETTE0_RESET = 24'h000000;
   localparam logic [23:0] PALETTE1_RESET = 24'hFFFFFF;
   localparam logic [23:0] PALETTE2_RESET = 24'hFFDC00;
   localparam logic [23:0] PALETTE3_RESET = 24'hC80000;
   localparam logic [7:0]  CODES_RESET    = 8'hE4;
   localparam logic [1:0]  FILL_RESET     = 2'd1;
   localparam logic [10:0] WIDTH_RESET    = 11'd648;

   // reciprocals for floor(v*255/31) and floor(v*255/63), exact over the input range
   localparam logic [31:0] SCALE5 = 32'd255 * 32'd33826;
   localparam logic [31:0] SCALE6 = 32'd255 * 32'd16645;
   localparam int          RECIP_SHIFT = 20;

   typedef logic [23:0] rgb_type;

   // widen a 5-bit channel to 8 bits, truncating
   function automatic logic [7:0] widen5(input logic [4:0] v);
      logic [31:0] p;
      p = {27'd0, v} * SCALE5;
      return p[RECIP_SHIFT+7:RECIP_SHIFT];
   endfunction

   // widen a 6-bit channel to 8 bits, truncating
   function automatic logic [7:0] widen6(input logic [5:0] v);
      logic [31:0] p;
      p = {26'd0, v} * SCALE6;
      return p[RECIP_SHIFT+7:RECIP_SHIFT];
   endfunction

   // squared difference of two 8-bit channels
   function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return {8'd0, d} * {8'd0, d};
   endfunction

   // squared distance between a pixel and a palette colour
   function automatic logic [17:0] colour_dist(input rgb_type px, input rgb_type pal);
      return {2'd0, sq_diff(px[23:16], pal[23:16])}
           + {2'd0, sq_diff(px[15:8],  pal[15:8])}
           + {2'd0, sq_diff(px[7:0],   pal[7:0])};
   endfunction

endpackage

/* src/rgb565_palette_quantize_pack_top.sv */
// Palette quantiser and 2-bit packer. Takes one RGB565 pixel per clock on the req_ channel
// while req_stall is low, widens it to 8-bit RGB, picks the nearest of four palette colours
// (squared distance, lower entry wins ties) and packs the entry's panel code four to a byte,
// first pixel in bits 7:6. A byte appears on the rsp_ channel after every fourth kept pixel,
// and at the last kept pixel of a line (padded with the fill code, last_of_line set). Pixels
// past line_width are dropped. One item per clock is sustained while rsp_stall is low, set
// by the single pass from the input register through the four distance units to the result
// register. Registers are to be written through csr_ only while no item is in flight; the
// block does not enforce this. csr_ready is always high.
module rgb565_palette_quantize_pack_top
   import rpqp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [15:0]            req_pixel_rgb565,
   input  logic                   req_line_end,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_packed_byte,
   output logic [7:0]             rsp_byte_column,
   output logic                   rsp_last_of_line,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // configuration registers
   rgb_type     palette_ff [4];
   logic [7:0]  codes_ff;
   logic [1:0]  fill_ff;
   logic [10:0] width_ff;

   // input register
   logic        s1_valid_ff, s1_valid_in;
   logic [15:0] s1_pixel_ff;
   logic        s1_end_ff;

   // line state
   logic [COL_W-1:0] column_ff, column_in;
   logic [5:0]       partial_ff, partial_in;
   logic [1:0]       pending_ff, pending_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] byte_ff;
   logic [7:0] bcol_ff;
   logic       last_ff;

   logic             out_free;
   logic             s1_done;
   logic [COL_W-1:0] width_eff;
   logic             keep;
   logic             last;
   logic             emit;
   rgb_type          px_rgb;
   logic [17:0]      pal_dist [4];
   logic [1:0]       best;
   logic [1:0]       code;
   logic [7:0]       packed_byte;

   assign csr_ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         palette_ff[0] <= PALETTE0_RESET;
         palette_ff[1] <= PALETTE1_RESET;
         palette_ff[2] <= PALETTE2_RESET;
         palette_ff[3] <= PALETTE3_RESET;
         codes_ff      <= CODES_RESET;
         fill_ff       <= FILL_RESET;
         width_ff      <= WIDTH_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PALETTE0: palette_ff[0] <= csr_data[23:0];
            CSR_PALETTE1: palette_ff[1] <= csr_data[23:0];
            CSR_PALETTE2: palette_ff[2] <= csr_data[23:0];
            CSR_PALETTE3: palette_ff[3] <= csr_data[23:0];
            CSR_CODES:    codes_ff      <= csr_data[7:0];
            CSR_FILL:     fill_ff       <= csr_data[1:0];
            CSR_WIDTH:    width_ff      <= csr_data[10:0];
            default: begin
            end
         endcase
      end
   end

   // widen and find the nearest palette entry
   always_comb begin
      px_rgb = {widen5(s1_pixel_ff[15:11]), widen6(s1_pixel_ff[10:5]),
                widen5(s1_pixel_ff[4:0])};
      for (int i = 0; i < 4; i++) begin
         pal_dist[i] = colour_dist(px_rgb, palette_ff[i]);
      end
   end

   always_comb begin
      logic [1:0]  lo_idx, hi_idx;
      logic [17:0] lo_d, hi_d;
      lo_idx = (pal_dist[0] <= pal_dist[1]) ? 2'd0 : 2'd1;
      lo_d   = (pal_dist[0] <= pal_dist[1]) ? pal_dist[0] : pal_dist[1];
      hi_idx = (pal_dist[2] <= pal_dist[3]) ? 2'd2 : 2'd3;
      hi_d   = (pal_dist[2] <= pal_dist[3]) ? pal_dist[2] : pal_dist[3];
      best   = (lo_d <= hi_d) ? lo_idx : hi_idx;
      code   = codes_ff[{best, 1'b0} +: 2];
   end

   // packing and line bookkeeping
   always_comb begin
      width_eff = (width_ff > COL_W'(MAX_LINE_PIXELS)) ? COL_W'(MAX_LINE_PIXELS) : width_ff;
      keep      = column_ff < width_eff;
      last      = s1_end_ff || ((column_ff + 1'b1) == width_eff);
      emit      = s1_valid_ff && keep && ((pending_ff == 2'd3) || last);

      case (pending_ff)
         2'd0:    packed_byte = {code, fill_ff, fill_ff, fill_ff};
         2'd1:    packed_byte = {partial_ff[1:0], code, fill_ff, fill_ff};
         2'd2:    packed_byte = {partial_ff[3:0], code, fill_ff};
         default: packed_byte = {partial_ff, code};
      endcase

      column_in  = column_ff;
      partial_in = partial_ff;
      pending_in = pending_ff;
      if (s1_done) begin
         if (s1_end_ff) begin
            column_in  = '0;
            partial_in = '0;
            pending_in = '0;
         end else if (keep) begin
            column_in = column_ff + 1'b1;
            if (emit) begin
               partial_in = '0;
               pending_in = '0;
            end else begin
               partial_in = {partial_ff[3:0], code};
               pending_in = pending_ff + 1'b1;
            end
         end
      end
   end

   // handshake between the stages
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign s1_done      = s1_valid_ff && (!emit || out_free);
   assign req_stall    = s1_valid_ff && !s1_done;
   assign s1_valid_in  = req_valid ? 1'b1 : (s1_valid_ff && !s1_done);
   assign rsp_valid_in = emit && out_free ? 1'b1 : (rsp_valid_ff && rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         column_ff    <= '0;
         partial_ff   <= '0;
         pending_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         column_ff    <= column_in;
         partial_ff   <= partial_in;
         pending_ff   <= pending_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_pixel_ff <= req_pixel_rgb565;
         s1_end_ff   <= req_line_end;
      end
      if (emit && out_free) begin
         byte_ff <= packed_byte;
         bcol_ff <= column_ff[9:2];
         last_ff <= last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_packed_byte  = byte_ff;
   assign rsp_byte_column  = bcol_ff;
   assign rsp_last_of_line = last_ff;

   // checks
   a_column_bound: assert property (@(posedge clock) disable iff (reset)
      column_ff <= COL_W'(MAX_LINE_PIXELS))
      else $error("column count beyond the line limit");

   a_pending_aligned: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd0 |-> column_ff[1:0] == pending_ff)
      else $error("pending pixel count out of step with the column");

   a_emit_lands: assert property (@(posedge clock) disable iff (reset)
      s1_done && emit |=> rsp_valid_ff)
      else $error("emitted byte did not reach the result register");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !(s1_done && emit))
      else $error("result overwritten while stalled");

endmodule

/* tb/tb_rgb565_palette_quantize_pack_top.sv */
`timescale 1ns / 100ps

module tb_rgb565_palette_quantize_pack_top;
   import rpqp_pkg::*;

   // one emitted byte of panel codes
   typedef struct packed {
      logic [7:0] packed_byte;
      logic [7:0] byte_column;
      logic       last_of_line;
   } panel_byte_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [15:0]            req_pixel_rgb565 = '0;
   logic                   req_line_end = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [7:0]             rsp_packed_byte;
   logic [7:0]             rsp_byte_column;
   logic                   rsp_last_of_line;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // predictor copy of the registers, at their reset values
   rgb_type     palette_rgb [4] = '{24'h000000, 24'hFFFFFF, 24'hFFDC00, 24'hC80000};
   logic [7:0]  code_map = 8'hE4;
   logic [1:0]  pad_code = 2'd1;
   logic [10:0] kept_width = 11'd648;

   // predictor copy of the line state
   int          line_column = 0;
   logic [5:0]  pending_codes = '0;
   int          pending_count = 0;

   panel_byte_type expected_bytes [$];
   int          failures = 0;
   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;

   rgb565_palette_quantize_pack_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel_rgb565 (req_pixel_rgb565),
      .req_line_end     (req_line_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_packed_byte  (rsp_packed_byte),
      .rsp_byte_column  (rsp_byte_column),
      .rsp_last_of_line (rsp_last_of_line),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #4 clock = ~clock;

   // panel code of the palette entry nearest to a pixel, lower entry on a tie
   function automatic logic [1:0] nearest_panel_code(input logic [15:0] px);
      int r, g, b, dr, dg, db, sq_dist, best, best_dist;
      r = int'(px[15:11]) * 255 / 31;
      g = int'(px[10:5]) * 255 / 63;
      b = int'(px[4:0]) * 255 / 31;
      best = 0;
      best_dist = 32'h7FFF_FFFF;
      for (int i = 0; i < 4; i++) begin
         dr = r - int'(palette_rgb[i][23:16]);
         dg = g - int'(palette_rgb[i][15:8]);
         db = b - int'(palette_rgb[i][7:0]);
         sq_dist = dr * dr + dg * dg + db * db;
         if (sq_dist < best_dist) begin
            best_dist = sq_dist;
            best = i;
         end
      end
      return code_map[2 * best +: 2];
   endfunction

   // advance the line state by one accepted pixel, queueing any byte it completes
   function automatic void predict_pixel(input logic [15:0] px, input logic le);
      int          width;
      int          cnt;
      logic [7:0]  acc;
      logic        last;
      panel_byte_type pb;
      width = (kept_width < MAX_LINE_PIXELS) ? kept_width : MAX_LINE_PIXELS;
      if (line_column < width) begin
         acc = {pending_codes, nearest_panel_code(px)};
         cnt = pending_count + 1;
         last = le || (line_column + 1 == width);
         if (cnt == 4 || last) begin
            while (cnt < 4) begin
               acc = {acc[5:0], pad_code};
               cnt++;
            end
            pb.packed_byte = acc;
            pb.byte_column = 8'(line_column >> 2);
            pb.last_of_line = last;
            expected_bytes.push_back(pb);
            pending_codes = '0;
            pending_count = 0;
         end else begin
            pending_codes = acc[5:0];
            pending_count = cnt;
         end
         line_column++;
      end
      if (le) begin
         line_column = 0;
         pending_codes = '0;
         pending_count = 0;
      end
   endfunction

   // offer one pixel, with a random gap first, and predict it once taken
   task automatic send_pixel(input logic [15:0] px, input logic le);
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_rgb565 <= px;
      req_line_end <= le;
      do @(posedge clock); while (req_stall);
      predict_pixel(px, le);
   endtask

   // hold off the sender until every queued byte has come out
   task automatic wait_until_drained();
      int waited = 0;
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0 && waited < 4000) begin
         @(posedge clock);
         waited++;
      end
      if (expected_bytes.size() != 0) begin
         $error("%0d expected bytes never arrived", expected_bytes.size());
         failures += expected_bytes.size();
         expected_bytes.delete();
      end
      // items that emit nothing may still be in the pipe
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [23:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PALETTE0: palette_rgb[0] = data;
         CSR_PALETTE1: palette_rgb[1] = data;
         CSR_PALETTE2: palette_rgb[2] = data;
         CSR_PALETTE3: palette_rgb[3] = data;
         CSR_CODES:    code_map = data[7:0];
         CSR_FILL:     pad_code = data[1:0];
         CSR_WIDTH:    kept_width = data[10:0];
         default: ;
      endcase
   endtask

   // rewrite every register once idle; unused upper data bits carry noise
   task automatic apply_settings(input rgb_type p0, input rgb_type p1, input rgb_type p2,
                                 input rgb_type p3, input logic [7:0] codes,
                                 input logic [1:0] fill, input logic [10:0] width);
      wait_until_drained();
      write_register(CSR_PALETTE0, p0);
      write_register(CSR_PALETTE1, p1);
      write_register(CSR_PALETTE2, p2);
      write_register(CSR_PALETTE3, p3);
      write_register(CSR_CODES, 24'(($urandom & 24'hFFFF00) | codes));
      write_register(CSR_FILL, 24'(($urandom & 24'hFFFFFC) | fill));
      write_register(CSR_WIDTH, 24'(($urandom & 24'hFFF800) | width));
      csr_valid <= 1'b0;
   endtask

   function automatic rgb_type random_colour(input bit few_colours);
      if (few_colours) begin
         case ($urandom_range(3))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            2: return 24'h808080;
            default: return 24'hFF0000;
         endcase
      end
      return rgb_type'($urandom);
   endfunction

   // reset palette: full byte, padded partial bytes of one, two and three pixels
   task automatic test_reset_config();
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'hF800, 1'b0);
      send_pixel(16'h07E0, 1'b0);
      send_pixel(16'h001F, 1'b0);
      send_pixel(16'hFFE0, 1'b1);
      send_pixel(16'h8410, 1'b1);
      send_pixel(16'hFEE0, 1'b0);
      send_pixel(16'h4208, 1'b0);
      send_pixel(16'h7BEF, 1'b1);
   endtask

   // width reached before line end, single pixel lines, and a width that keeps nothing
   task automatic test_narrow_widths();
      apply_settings(palette_rgb[0], palette_rgb[1], palette_rgb[2], palette_rgb[3],
                     code_map, 2'd3, 11'd3);
      for (int k = 0; k < 5; k++) send_pixel(16'(k * 16'h3333), k == 4);
      apply_settings(palette_rgb[0], palette_rgb[1], palette_rgb[2], palette_rgb[3],
                     code_map, 2'd2, 11'd1);
      send_pixel(16'hC000, 1'b0);
      send_pixel(16'h1234, 1'b1);
      apply_settings(palette_rgb[0], palette_rgb[1], palette_rgb[2], palette_rgb[3],
                     code_map, 2'd0, 11'd0);
      send_pixel(16'hABCD, 1'b0);
      send_pixel(16'h5432, 1'b1);
   endtask

   // duplicated entry and equidistant colours, lowest entry must win
   task automatic test_palette_ties();
      apply_settings(24'hFF0000, 24'h00FF00, 24'h00FF00, 24'h0000FF, 8'h1B, 2'd0, 11'd1024);
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'h07E0, 1'b0);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'h001F, 1'b1);
   endtask

   // random settings and whole lines of random pixels, some longer than the width
   task automatic test_random_lines(input int idle_pct, input int stall_pct, input int n_items);
      int          sent = 0;
      int          len;
      int          max_len;
      bit          few;
      logic [10:0] width;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      while (sent < n_items) begin
         few = ($urandom_range(3) == 0);
         case ($urandom_range(7))
            0: width = 11'd1;
            1: width = 11'd1024;
            2: width = 11'($urandom_range(8, 2));
            default: width = 11'($urandom_range(40, 1));
         endcase
         apply_settings(random_colour(few), random_colour(few), random_colour(few),
                        random_colour(few), 8'($urandom_range(255)),
                        2'($urandom_range(3)), width);
         repeat (4) begin
            max_len = (width + 4 > 48) ? 48 : width + 4;
            len = $urandom_range(max_len, 1);
            for (int k = 0; k < len; k++) send_pixel(16'($urandom_range(16'hFFFF)), k == len - 1);
            sent += len;
         end
      end
   endtask

   // width register above the line limit: kept part clamps, column runs to the top
   task automatic test_clamped_width();
      sender_idle_pct = 33;
      receiver_stall_pct = 33;
      apply_settings(random_colour(1'b0), random_colour(1'b0), random_colour(1'b0),
                     random_colour(1'b0), 8'($urandom_range(255)), 2'($urandom_range(3)),
                     11'h7FF);
      for (int k = 0; k < MAX_LINE_PIXELS + 2; k++)
         send_pixel(16'($urandom_range(16'hFFFF)), k == MAX_LINE_PIXELS + 1);
   endtask

   // result side: random stall, compare each taken byte with the oldest prediction
   always @(posedge clock) begin
      panel_byte_type want;
      rsp_stall <= (receiver_stall_pct != 0) && ($urandom_range(99) < receiver_stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            $error("unexpected byte %02h at column %0d", rsp_packed_byte, rsp_byte_column);
            failures++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_packed_byte !== want.packed_byte) begin
               $error("packed_byte: expected %02h, actual %02h",
                      want.packed_byte, rsp_packed_byte);
               failures++;
            end
            if (rsp_byte_column !== want.byte_column) begin
               $error("byte_column: expected %0d, actual %0d",
                      want.byte_column, rsp_byte_column);
               failures++;
            end
            if (rsp_last_of_line !== want.last_of_line) begin
               $error("last_of_line: expected %0b, actual %0b",
                      want.last_of_line, rsp_last_of_line);
               failures++;
            end
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      test_reset_config();
      test_narrow_widths();
      test_palette_ties();
      test_random_lines(0, 0, 110);
      test_random_lines(46, 0, 110);
      test_random_lines(0, 46, 110);
      test_random_lines(33, 33, 110);
      test_clamped_width();
      wait_until_drained();
      if (failures == 0) begin
         $display("rgb565_palette_quantize_pack_top test passed");
      end else begin
         $display("rgb565_palette_quantize_pack_top test failed");
      end
      $finish;
   end

   // hang guard
   initial begin
      #2_000_000;
      $display("rgb565_palette_quantize_pack_top test failed");
      $finish;
   end

endmodule
